>>> hdl/kslpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key short/long press detector.
// No dependencies; imported by kslpd_eval and key_short_long_press_detector.
package kslpd_pkg;

    localparam int unsigned NUM_TIMED_KEYS = 7;
    localparam int unsigned PADDR_W        = 5;

    localparam logic [15:0] REPEAT_TICKS = 16'd200;
    localparam logic [31:0] SHORT_TICKS  = 32'd80;
    localparam logic [15:0] DEFAULT_HOLD = 16'd5000;

    localparam logic [15:0] HOLD_RESET [NUM_TIMED_KEYS] = '{
        16'd5000, 16'd5000, 16'd5000, 16'd1000, 16'd1000, 16'd5000, 16'd5000
    };

    // Register indexes; long-press times occupy indexes 0..6
    localparam logic [2:0] REG_LONG_TIME_BASE = 3'd0;
    localparam logic [2:0] REG_REPEAT_MASK    = 3'd7;

    typedef struct packed {
        logic [31:0] now_ticks;
        logic [6:0]  key_levels;
    } t_scan_in;

    typedef struct packed {
        logic [2:0] key_index;
        logic       is_long;
        logic       last_event;
    } t_key_event;

    typedef struct packed {
        logic        locked;
        logic [31:0] stamp;
    } t_key_entry;

    typedef struct packed {
        logic       ev;
        logic       is_long;
        t_key_entry next;
    } t_eval_res;

endpackage

>>> hdl/key_short_long_press_detector.sv
`timescale 1ns / 1ps
// Key short/long press detector: one scan beat in, up to NUM_KEYS event beats out.
// Each event is held in a pending register, then in the output register, before it leaves.
// Per scan: accept, then one key per cycle through the state memory with one read and
// one write per cycle (a key is held while the output is stalled and an event is pending),
// then one flush step; the next scan is accepted only after the flush.
// Reset: control state clears, key state reads as zero until written, registers
// return to their reset values. No clearing pass.
module key_short_long_press_detector
    import kslpd_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // scan input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_scan_in           i_in_data,
    // event output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_key_event         o_out_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH
    } t_state;

    // configuration registers
    logic [15:0] r_long_time [NUM_TIMED_KEYS];
    logic [6:0]  r_repeat;
    logic [2:0]  w_reg_idx;

    // state memory
    t_key_entry  r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_vbits;
    t_key_entry  r_rd_entry;
    logic        r_rd_ok;
    logic        w_rd_en;
    logic [KW-1:0] w_rd_addr;
    logic        w_mem_we;
    t_key_entry  w_entry;

    // control
    t_state      r_state, n_state;
    logic [KW-1:0] r_key;
    logic [31:0] r_now;
    logic [6:0]  r_levels;
    logic        r_pend_valid;
    logic [2:0]  r_pend_idx;
    logic        r_pend_long;

    logic        w_accept;
    logic        w_can_push;
    logic        w_push;
    logic        w_adv;
    logic        w_last_key;
    logic [2:0]  w_key3;
    logic        w_timed;
    logic        w_pressed;
    logic [15:0] w_hold;
    logic        w_rep;
    t_eval_res   w_res;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMED_KEYS; i++) begin
                r_long_time[i] <= HOLD_RESET[i];
            end
            r_repeat <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_REPEAT_MASK: r_repeat <= pwdata[6:0];
                default:         r_long_time[w_reg_idx - REG_LONG_TIME_BASE] <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_REPEAT_MASK: prdata = 32'(r_repeat);
            default:         prdata = 32'(r_long_time[w_reg_idx - REG_LONG_TIME_BASE]);
        endcase
    end

    // ---------------- key evaluation ----------------
    assign w_key3    = 3'(r_key);
    assign w_timed   = (32'(r_key) < NUM_TIMED_KEYS);
    assign w_pressed = w_timed && r_levels[w_key3];
    assign w_hold    = w_timed ? r_long_time[w_key3] : DEFAULT_HOLD;
    assign w_rep     = w_timed && r_repeat[w_key3];
    assign w_entry   = r_rd_ok ? r_rd_entry : '0;

    kslpd_eval u_eval (
        .i_entry   (w_entry),
        .i_pressed (w_pressed),
        .i_hold    (w_hold),
        .i_repeat  (w_rep),
        .i_now     (r_now),
        .o_res     (w_res)
    );

    // ---------------- handshake / sequencing ----------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_can_push = !o_out_valid || !i_out_stall;
    assign w_last_key = (r_key == KW'(NUM_KEYS - 1));

    // a new event with one already pending needs room in the output register
    assign w_adv  = !(w_res.ev && r_pend_valid && !w_can_push);
    assign w_push = r_pend_valid && w_can_push &&
                    (((r_state == S_EVAL) && w_res.ev) || (r_state == S_FLUSH));

    assign w_mem_we  = (r_state == S_EVAL) && w_adv;
    assign w_rd_en   = w_accept || ((r_state == S_EVAL) && w_adv && !w_last_key);
    assign w_rd_addr = (r_state == S_IDLE) ? '0 : KW'(r_key + KW'(1));

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_key] <= w_res.next;
        end
        if (w_rd_en) begin
            r_rd_entry <= r_mem[w_rd_addr];
            r_rd_ok    <= r_vbits[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EVAL;
            S_EVAL:  if (w_adv && w_last_key) n_state = S_FLUSH;
            S_FLUSH: if (!r_pend_valid || w_can_push) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key        <= '0;
            r_vbits      <= '0;
            r_pend_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_now    <= i_in_data.now_ticks;
                r_levels <= i_in_data.key_levels;
                r_key    <= '0;
            end

            if (w_mem_we) begin
                r_vbits[r_key] <= 1'b1;
                if (!w_last_key) begin
                    r_key <= KW'(r_key + KW'(1));
                end
                if (w_res.ev) begin
                    r_pend_valid <= 1'b1;
                    r_pend_idx   <= w_key3;
                    r_pend_long  <= w_res.is_long;
                end
            end

            if ((r_state == S_FLUSH) && w_can_push) begin
                r_pend_valid <= 1'b0;
            end

            // held event leaves once the next one shows up or the scan ends
            if (w_push) begin
                o_out_valid           <= 1'b1;
                o_out_data.key_index  <= r_pend_idx;
                o_out_data.is_long    <= r_pend_long;
                o_out_data.last_event <= (r_state == S_FLUSH);
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- assertions ----------------
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending event left over in idle");

    a_last_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (r_state != S_FLUSH)) |=> !o_out_data.last_event)
        else $error("last_event set before scan end");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_key) < NUM_KEYS)
        else $error("key counter out of range");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL) && (r_key == '0))
        else $error("scan did not start at key zero");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_push)
        else $error("event overwrote a stalled beat");

endmodule

>>> hdl/kslpd_eval.sv
`timescale 1ns / 1ps
// Per-key press evaluation: next timestamp/lock state and event decision.
// Depends on kslpd_pkg.
module kslpd_eval
    import kslpd_pkg::*;
(
    input  t_key_entry  i_entry,
    input  logic        i_pressed,
    input  logic [15:0] i_hold,
    input  logic        i_repeat,
    input  logic [31:0] i_now,
    output t_eval_res   o_res
);

    logic [31:0] w_elapsed;
    logic [15:0] w_limit;

    assign w_elapsed = i_now - i_entry.stamp;   // wraps mod 2^32
    assign w_limit   = i_entry.locked ? REPEAT_TICKS : i_hold;

    always_comb begin
        o_res.ev      = 1'b0;
        o_res.is_long = 1'b0;
        o_res.next    = i_entry;
        if (i_pressed) begin
            if (!i_entry.locked || i_repeat) begin
                if (w_elapsed > {16'b0, w_limit}) begin
                    o_res.ev          = 1'b1;
                    o_res.is_long     = 1'b1;
                    o_res.next.locked = 1'b1;
                    o_res.next.stamp  = i_now;
                end
            end else begin
                // locked, no repeat: stamp tracks the hold
                o_res.next.stamp = i_now;
            end
        end else begin
            o_res.ev          = (w_elapsed > SHORT_TICKS);
            o_res.next.locked = 1'b0;
            o_res.next.stamp  = i_now;
        end
    end

endmodule
